// ===== hw/rtl/color_axis_channel_extract_defines.svh =====
// ----------------------------------------------------------------------------
// Color axis channel extract: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef COLOR_AXIS_CHANNEL_EXTRACT_DEFINES_SVH
`define COLOR_AXIS_CHANNEL_EXTRACT_DEFINES_SVH

// same-cycle implication
`define CCX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccx assertion failed");

// next-cycle implication
`define CCX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccx assertion failed");

`endif

// ===== hw/rtl/ccx_pkg.sv =====
// ----------------------------------------------------------------------------
// ccx_pkg
// Widths, axis codes and small helpers for the color axis channel extractor.
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CH_W      = FRAC_BITS + 1;        // channel, 1.0 inclusive
  localparam int SQ_W      = 2 * FRAC_BITS + 1;    // square of a channel
  localparam int DIST_W    = 2 * FRAC_BITS + 4;    // distance scaled by 6
  localparam int NUM_W     = CH_W + 1;             // coordinate numerator
  localparam int LO_W      = NUM_W;                // low slice of sec
  localparam int HI_W      = DIST_W - LO_W;        // high slice of sec
  localparam int DEN_W     = DIST_W + 2;           // den * (min + sec)
  localparam int PROD_W    = NUM_W + DIST_W;       // num * sec
  localparam int QUO_W     = CH_W;                 // quotient bits
  localparam int REM_W     = DEN_W;                // divider remainder

  localparam logic [CH_W-1:0]   FX_ONE   = CH_W'(1) << FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(6) << (2 * FRAC_BITS);

  typedef logic [CH_W-1:0]   ch_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef enum logic [2:0] {
    AX_NONE = 3'd0,
    AX_R    = 3'd1,
    AX_G    = 3'd2,
    AX_B    = 3'd3,
    AX_C    = 3'd4,
    AX_M    = 3'd5,
    AX_Y    = 3'd6,
    AX_W    = 3'd7
  } axis_t;

  typedef struct packed {
    dist_t lo;
    dist_t hi;
  } pair_t;

  function automatic ch_t clamp_one(ch_t v);
    return (v > FX_ONE) ? FX_ONE : v;
  endfunction

  function automatic ch_t abs_diff(ch_t a, ch_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic pair_t sort2(dist_t a, dist_t b);
    pair_t p;
    p.lo = (a <= b) ? a : b;
    p.hi = (a <= b) ? b : a;
    return p;
  endfunction

  // two smallest of the union of two sorted pairs
  function automatic pair_t merge2(pair_t a, pair_t b);
    pair_t p;
    if (a.lo <= b.lo) begin
      p.lo = a.lo;
      p.hi = (a.hi <= b.lo) ? a.hi : b.lo;
    end else begin
      p.lo = b.lo;
      p.hi = (b.hi <= a.lo) ? b.hi : a.lo;
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/ccx_pix_if.sv =====
// ----------------------------------------------------------------------------
// ccx_pix_if
// Pixel channel: color channels and tolerance with valid/ready.
// ----------------------------------------------------------------------------
interface ccx_pix_if;
  logic          valid;
  logic          ready;
  ccx_pkg::ch_t  red_in;
  ccx_pkg::ch_t  green_in;
  ccx_pkg::ch_t  blue_in;
  ccx_pkg::ch_t  tolerance_in;

  modport source (output valid, red_in, green_in, blue_in, tolerance_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, tolerance_in, output ready);
endinterface

// ===== hw/rtl/ccx_res_if.sv =====
// ----------------------------------------------------------------------------
// ccx_res_if
// Result channel: extracted value and nearest axis with valid/ready.
// ----------------------------------------------------------------------------
interface ccx_res_if;
  logic          valid;
  logic          ready;
  ccx_pkg::ch_t  value_out;
  logic [2:0]    category_out;

  modport source (output valid, value_out, category_out, input ready);
  modport sink   (input valid, value_out, category_out, output ready);
endinterface

// ===== hw/rtl/ccx_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ccx_cfg_if
// Configuration write channel for the select mode register.
// ----------------------------------------------------------------------------
interface ccx_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] select_mode;

  modport source (output valid, select_mode, input ready);
  modport sink   (input valid, select_mode, output ready);
endinterface

// ===== hw/rtl/color_axis_channel_extract.sv =====
// ----------------------------------------------------------------------------
// color_axis_channel_extract
// Nearest color axis search with weighted projection and tolerance gate.
// ----------------------------------------------------------------------------
// Usage:
//   pix : pixel transfers in (red/green/blue/tolerance, 1.0 = 65536).
//   res : one result transfer out per pixel (value_out, category_out).
//   cfg : select_mode writes; always ready, write only while idle.
// Throughput: one pixel per cycle unless res stalls. The pipeline is
//   8 arithmetic stages, a 17-stage restoring divider (one quotient bit
//   per stage) and the output register.
// Reset: rst clears every stage valid and sets select_mode to 0.
// Stall: when res holds a result that is not taken, the whole pipe
//   freezes and pix.ready drops in the same cycle; nothing is lost or
//   repeated. A bubble in the output register keeps pix.ready high.
// ----------------------------------------------------------------------------
`include "color_axis_channel_extract_defines.svh"

module color_axis_channel_extract (
  input  logic       clk,
  input  logic       rst,
  ccx_pix_if.sink    pix,
  ccx_res_if.source  res,
  ccx_cfg_if.sink    cfg
);

  localparam int NST = 8;   // stages ahead of the divider

  // ---------------- configuration ----------------
  logic [2:0] select_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= ccx_pkg::AX_NONE;
    end else if (cfg.valid) begin
      select_mode <= cfg.select_mode;
    end
  end

  // ---------------- flow control ----------------
  // One global advance: the pipe moves whenever the output slot frees.
  logic o_v;
  logic adv;
  logic [NST:1] sv;                  // stage valids S1..S8
  logic [ccx_pkg::QUO_W:1] dvv;      // divider stage valids

  assign adv       = !o_v || res.ready;
  assign pix.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv  <= '0;
      dvv <= '0;
      o_v <= 1'b0;
    end else if (adv) begin
      sv  <= {sv[NST-1:1], pix.valid};
      dvv <= {dvv[ccx_pkg::QUO_W-1:1], sv[NST]};
      o_v <= dvv[ccx_pkg::QUO_W];
    end
  end

  // ---------------- S1: clamp ----------------
  ccx_pkg::ch_t s1_r, s1_g, s1_b, s1_tol;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= ccx_pkg::clamp_one(pix.red_in);
      s1_g   <= ccx_pkg::clamp_one(pix.green_in);
      s1_b   <= ccx_pkg::clamp_one(pix.blue_in);
      s1_tol <= ccx_pkg::clamp_one(pix.tolerance_in);
    end
  end

  // ---------------- S2: squares and squared differences ----------------
  // operands widened first: 1.0 squared needs the full SQ_W bits
  ccx_pkg::ch_t s2_r, s2_g, s2_b, s2_tol;
  ccx_pkg::sq_t s2_rr, s2_gg, s2_bb, s2_gb, s2_rb, s2_rg;
  ccx_pkg::ch_t dgb, drb, drg;

  assign dgb = ccx_pkg::abs_diff(s1_g, s1_b);
  assign drb = ccx_pkg::abs_diff(s1_r, s1_b);
  assign drg = ccx_pkg::abs_diff(s1_r, s1_g);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r   <= s1_r;
      s2_g   <= s1_g;
      s2_b   <= s1_b;
      s2_tol <= s1_tol;
      s2_rr  <= ccx_pkg::sq_t'(s1_r) * ccx_pkg::sq_t'(s1_r);
      s2_gg  <= ccx_pkg::sq_t'(s1_g) * ccx_pkg::sq_t'(s1_g);
      s2_bb  <= ccx_pkg::sq_t'(s1_b) * ccx_pkg::sq_t'(s1_b);
      s2_gb  <= ccx_pkg::sq_t'(dgb) * ccx_pkg::sq_t'(dgb);
      s2_rb  <= ccx_pkg::sq_t'(drb) * ccx_pkg::sq_t'(drb);
      s2_rg  <= ccx_pkg::sq_t'(drg) * ccx_pkg::sq_t'(drg);
    end
  end

  // ---------------- S3: rejection distances (x6) ----------------
  ccx_pkg::ch_t  s3_r, s3_g, s3_b, s3_tol;
  ccx_pkg::dist_t s3_d [7];
  ccx_pkg::dist_t d3   [7];

  always_comb begin
    d3[0] = ccx_pkg::DIST_W'(6) * (ccx_pkg::DIST_W'(s2_gg) + ccx_pkg::DIST_W'(s2_bb));
    d3[1] = ccx_pkg::DIST_W'(6) * (ccx_pkg::DIST_W'(s2_rr) + ccx_pkg::DIST_W'(s2_bb));
    d3[2] = ccx_pkg::DIST_W'(6) * (ccx_pkg::DIST_W'(s2_rr) + ccx_pkg::DIST_W'(s2_gg));
    d3[3] = ccx_pkg::DIST_W'(6) * ccx_pkg::DIST_W'(s2_rr)
          + ccx_pkg::DIST_W'(3) * ccx_pkg::DIST_W'(s2_gb);
    d3[4] = ccx_pkg::DIST_W'(6) * ccx_pkg::DIST_W'(s2_gg)
          + ccx_pkg::DIST_W'(3) * ccx_pkg::DIST_W'(s2_rb);
    d3[5] = ccx_pkg::DIST_W'(6) * ccx_pkg::DIST_W'(s2_bb)
          + ccx_pkg::DIST_W'(3) * ccx_pkg::DIST_W'(s2_rg);
    d3[6] = ccx_pkg::DIST_W'(2) * (ccx_pkg::DIST_W'(s2_rg) + ccx_pkg::DIST_W'(s2_gb)
          + ccx_pkg::DIST_W'(s2_rb));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r   <= s2_r;
      s3_g   <= s2_g;
      s3_b   <= s2_b;
      s3_tol <= s2_tol;
      s3_d   <= d3;
    end
  end

  // ---------------- S4: pair sort and first merge ----------------
  // min/sec are the two smallest of the distances plus two copies of 1.0.
  ccx_pkg::ch_t   s4_r, s4_g, s4_b, s4_tol;
  ccx_pkg::dist_t s4_d [7];
  ccx_pkg::pair_t s4_m0, s4_m1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r   <= s3_r;
      s4_g   <= s3_g;
      s4_b   <= s3_b;
      s4_tol <= s3_tol;
      s4_d   <= s3_d;
      s4_m0  <= ccx_pkg::merge2(ccx_pkg::sort2(s3_d[0], s3_d[1]),
                                ccx_pkg::sort2(s3_d[2], s3_d[3]));
      s4_m1  <= ccx_pkg::merge2(ccx_pkg::sort2(s3_d[4], s3_d[5]),
                                ccx_pkg::sort2(s3_d[6], ccx_pkg::DIST_ONE));
    end
  end

  // ---------------- S5: final merge ----------------
  ccx_pkg::ch_t   s5_r, s5_g, s5_b, s5_tol;
  ccx_pkg::dist_t s5_d [7];
  ccx_pkg::dist_t s5_mn, s5_sec;
  ccx_pkg::pair_t m5;

  assign m5 = ccx_pkg::merge2(s4_m0, s4_m1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r   <= s4_r;
      s5_g   <= s4_g;
      s5_b   <= s4_b;
      s5_tol <= s4_tol;
      s5_d   <= s4_d;
      s5_mn  <= m5.lo;
      s5_sec <= (m5.hi <= ccx_pkg::DIST_ONE) ? m5.hi : ccx_pkg::DIST_ONE;
    end
  end

  // ---------------- S6: nearest axis, distance sum ----------------
  ccx_pkg::ch_t   s6_r, s6_g, s6_b, s6_tol;
  ccx_pkg::dist_t s6_sec, s6_sum;
  ccx_pkg::axis_t s6_cat;
  logic           s6_hit;
  ccx_pkg::axis_t cat6;
  ccx_pkg::dist_t sum6;

  always_comb begin
    cat6 = ccx_pkg::AX_NONE;
    for (int i = 6; i >= 0; i--) begin
      if (s5_d[i] == s5_mn) cat6 = ccx_pkg::axis_t'(i + 1);
    end
  end

  assign sum6 = s5_mn + s5_sec;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_r   <= s5_r;
      s6_g   <= s5_g;
      s6_b   <= s5_b;
      s6_tol <= s5_tol;
      s6_sec <= s5_sec;
      s6_sum <= sum6;
      s6_cat <= cat6;
      // black pixel lands here too: every distance and the sum are zero
      s6_hit <= (cat6 != ccx_pkg::AX_NONE) && (sum6 != '0);
    end
  end

  // ---------------- S7: numerator, divisor, partial products ----------------
  logic [ccx_pkg::NUM_W-1:0] num7;
  logic [ccx_pkg::DEN_W-1:0] den7;
  logic [ccx_pkg::DEN_W-1:0] s7_den;
  logic [2*ccx_pkg::LO_W-1:0] s7_plo;
  logic [ccx_pkg::NUM_W+ccx_pkg::HI_W-1:0] s7_phi;
  ccx_pkg::axis_t s7_cat;
  logic           s7_hit;
  ccx_pkg::ch_t   s7_tol;

  always_comb begin
    case (s6_cat)
      ccx_pkg::AX_R: begin
        num7 = ccx_pkg::NUM_W'(s6_r);
        den7 = ccx_pkg::DEN_W'(s6_sum);
      end
      ccx_pkg::AX_G: begin
        num7 = ccx_pkg::NUM_W'(s6_g);
        den7 = ccx_pkg::DEN_W'(s6_sum);
      end
      ccx_pkg::AX_B: begin
        num7 = ccx_pkg::NUM_W'(s6_b);
        den7 = ccx_pkg::DEN_W'(s6_sum);
      end
      ccx_pkg::AX_C: begin
        num7 = ccx_pkg::NUM_W'(s6_g) + ccx_pkg::NUM_W'(s6_b);
        den7 = ccx_pkg::DEN_W'(s6_sum) << 1;
      end
      ccx_pkg::AX_M: begin
        num7 = ccx_pkg::NUM_W'(s6_r) + ccx_pkg::NUM_W'(s6_b);
        den7 = ccx_pkg::DEN_W'(s6_sum) << 1;
      end
      ccx_pkg::AX_Y: begin
        num7 = ccx_pkg::NUM_W'(s6_r) + ccx_pkg::NUM_W'(s6_g);
        den7 = ccx_pkg::DEN_W'(s6_sum) << 1;
      end
      ccx_pkg::AX_W: begin
        num7 = ccx_pkg::NUM_W'(s6_r) + ccx_pkg::NUM_W'(s6_g) + ccx_pkg::NUM_W'(s6_b);
        den7 = ccx_pkg::DEN_W'(s6_sum) + (ccx_pkg::DEN_W'(s6_sum) << 1);
      end
      default: begin
        num7 = '0;
        den7 = ccx_pkg::DEN_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_den <= den7;
      s7_plo <= num7 * s6_sec[ccx_pkg::LO_W-1:0];
      s7_phi <= num7 * s6_sec[ccx_pkg::DIST_W-1:ccx_pkg::LO_W];
      s7_cat <= s6_cat;
      s7_hit <= s6_hit;
      s7_tol <= s6_tol;
    end
  end

  // ---------------- S8: dividend assembly ----------------
  logic [ccx_pkg::PROD_W-1:0] n8;

  assign n8 = ccx_pkg::PROD_W'(s7_plo)
            + (ccx_pkg::PROD_W'(s7_phi) << ccx_pkg::LO_W);

  // divider pipe, index 0 is the S8 register
  logic [ccx_pkg::REM_W-1:0] dv_rem [ccx_pkg::QUO_W+1];
  logic [ccx_pkg::QUO_W-1:0] dv_low [ccx_pkg::QUO_W+1];
  logic [ccx_pkg::QUO_W-1:0] dv_q   [ccx_pkg::QUO_W+1];
  logic [ccx_pkg::DEN_W-1:0] dv_den [ccx_pkg::QUO_W+1];
  ccx_pkg::axis_t            dv_cat [ccx_pkg::QUO_W+1];
  logic                      dv_hit [ccx_pkg::QUO_W+1];
  ccx_pkg::ch_t              dv_tol [ccx_pkg::QUO_W+1];

  // quotient fits QUO_W bits, so the upper dividend bits are below the divisor
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= ccx_pkg::REM_W'(n8[ccx_pkg::PROD_W-1:ccx_pkg::QUO_W]);
      dv_low[0] <= n8[ccx_pkg::QUO_W-1:0];
      dv_q[0]   <= '0;
      dv_den[0] <= s7_den;
      dv_cat[0] <= s7_cat;
      dv_hit[0] <= s7_hit;
      dv_tol[0] <= s7_tol;
    end
  end

  // ---------------- restoring divider, one bit per stage ----------------
  for (genvar k = 0; k < ccx_pkg::QUO_W; k++) begin : g_div
    logic [ccx_pkg::REM_W:0]   trial;
    logic                      ge;
    logic [ccx_pkg::REM_W:0]   diff;

    assign trial = {dv_rem[k], dv_low[k][ccx_pkg::QUO_W-1]};
    assign ge    = trial >= {1'b0, dv_den[k]};
    assign diff  = trial - {1'b0, dv_den[k]};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k+1] <= ge ? diff[ccx_pkg::REM_W-1:0] : trial[ccx_pkg::REM_W-1:0];
        dv_low[k+1] <= dv_low[k] << 1;
        dv_q[k+1]   <= {dv_q[k][ccx_pkg::QUO_W-2:0], ge};
        dv_den[k+1] <= dv_den[k];
        dv_cat[k+1] <= dv_cat[k];
        dv_hit[k+1] <= dv_hit[k];
        dv_tol[k+1] <= dv_tol[k];
      end
    end
  end

  // ---------------- output register: tolerance and mode gate ----------------
  ccx_pkg::ch_t   o_value;
  ccx_pkg::axis_t o_cat;
  ccx_pkg::ch_t   qf;
  ccx_pkg::ch_t   gap;
  logic           pass;

  assign qf   = dv_q[ccx_pkg::QUO_W];
  assign gap  = (qf >= ccx_pkg::FX_ONE) ? '0 : ccx_pkg::FX_ONE - qf;
  assign pass = dv_hit[ccx_pkg::QUO_W]
             && (dv_cat[ccx_pkg::QUO_W] == ccx_pkg::axis_t'(select_mode))
             && (gap <= dv_tol[ccx_pkg::QUO_W]);

  always_ff @(posedge clk) begin
    if (adv) begin
      o_value <= pass ? qf : '0;
      o_cat   <= dv_hit[ccx_pkg::QUO_W] ? dv_cat[ccx_pkg::QUO_W] : ccx_pkg::AX_NONE;
    end
  end

  assign res.valid        = o_v;
  assign res.value_out    = o_value;
  assign res.category_out = o_cat;

  // ---------------- assertions ----------------
  `CCX_ASSERT_NOW(a_val_mode, res.valid && res.value_out != '0,
                  res.category_out == select_mode)
  `CCX_ASSERT_NOW(a_black_zero, res.valid && res.category_out == ccx_pkg::AX_NONE,
                  res.value_out == '0)
  `CCX_ASSERT_NOW(a_val_range, res.valid, res.value_out <= ccx_pkg::FX_ONE)
  `CCX_ASSERT_NOW(a_bubble_ready, !res.valid, pix.ready)

endmodule
